// ----- sv/plds_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// plds_pkg
// Shared types and constants for the synthesizer divider plan search.
// ----------------------------------------------------------------------------
package plds_pkg;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_CHECK,
      ST_DIV,
      ST_MUL,
      ST_EVAL,
      ST_ACT,
      ST_FIN
   } state_type;

   // Configuration register indexes
   localparam logic CSR_IDX_REFCLK = 1'b0;
   localparam logic CSR_IDX_OFFSET = 1'b1;

   localparam int REQ_W    = 32;
   localparam int REFCLK_W = 27;
   localparam int OFFSET_W = 25;
   localparam int T_W      = 34;
   localparam int N_W      = 15;
   localparam int D_W      = 28;
   localparam int BAND_N   = 7;

   localparam logic [REFCLK_W-1:0] REFCLK_RST = 27'd4000000;
   localparam logic [OFFSET_W-1:0] OFFSET_RST = 25'h185EE00; // -8000000

   localparam logic signed [T_W-1:0] T_MIN = 34'sd500000000;
   localparam logic signed [T_W-1:0] T_MAX = 34'sd2600000000;
   localparam logic [REQ_W-1:0]      HALF_MIN = 32'd1150000000;

   localparam logic [20:0] CLK_PER_R_MIN  = 21'd150000;  // r*150000 <= refclk
   localparam logic [20:0] CLK_PER_R_SKIP = 21'd2000000; // skip r*2e6 < refclk
   localparam logic [16:0] ERR_STOP       = 17'd75000;
   localparam logic [D_W-1:0] ERR_INIT    = 28'd10000000;
   localparam logic [N_W-1:0] N_MIN       = 15'd256;
   localparam logic [REQ_W-1:0] SAT_MAX   = 32'hFFFFFFFF;

   // VCO band thresholds in Hz, ascending
   localparam logic [T_W-1:0] BAND_EDGE [BAND_N] = '{
      34'd2433000000, 34'd2711000000, 34'd3025000000, 34'd3341000000,
      34'd3727000000, 34'd4143000000, 34'd4493000000
   };

endpackage
`default_nettype wire

// ----- sv/pll_divider_plan_search_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pll_divider_plan_search_unit
// Integer-N divider planner: offset, range check, band pick, divider search.
// ----------------------------------------------------------------------------
// Sequence: offset, then range check and band pick, then per reference divider
//   tried a check, a radix-2 restoring divider that rounds n, a multiply and an
//   evaluation; a divider ruled out by the reference clock costs only the check.
// Throughput: one beat at a time; req_stall is high from accept until the
//   result is loaded into the output register.
// Reset: synchronous, clears the sequencer and output valid and loads
//   refclk_hz = 4 MHz and lo_offset_hz = -8 MHz.

module pll_divider_plan_search_unit #(
   parameter int MAX_REF_DIV = 128
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // configuration
   input  wire logic                           csr_wr_en,
   input  wire logic                           csr_index,
   input  wire logic [plds_pkg::REFCLK_W-1:0]  csr_wdata,
   // request channel
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [plds_pkg::REQ_W-1:0]     req_requested_hz,
   // response channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_ok,
   output logic [2:0]                          rsp_ref_div_code,
   output logic [plds_pkg::N_W-1:0]            rsp_feedback_n,
   output logic                                rsp_half_mode,
   output logic [2:0]                          rsp_vco_band,
   output logic [plds_pkg::REQ_W-1:0]          rsp_actual_hz
);

   // Largest divider exponent: r = 2**k, k = 1 .. K_MAX
   localparam int K_MAX  = $clog2(MAX_REF_DIV + 1) - 1;
   localparam int K_W    = $clog2(K_MAX + 2);
   localparam int UT_W   = plds_pkg::REQ_W;
   localparam int RC_W   = plds_pkg::REFCLK_W;
   localparam int N_W    = plds_pkg::N_W;
   localparam int D_W    = plds_pkg::D_W;
   localparam int NUM_W  = UT_W + K_MAX + 2;
   localparam int DEN_W  = RC_W + N_W;
   localparam int DIV_W  = ((NUM_W > DEN_W) ? NUM_W : DEN_W) + 1;
   localparam int PROD_W = N_W + RC_W;
   localparam int TR_W   = UT_W + K_MAX;
   localparam int DIFF_W = ((PROD_W > TR_W) ? PROD_W : TR_W) + 1;
   localparam int CMP_W  = D_W + 4 + K_MAX;
   localparam int SH_W   = 21 + K_MAX + 1;
   localparam int ACT_W  = ((NUM_W > PROD_W) ? NUM_W : PROD_W) + 2;
   localparam int IDX_W  = $clog2(N_W);

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   plds_pkg::state_type state_ff, state_in;

   logic [RC_W-1:0]                   refclk_ff;
   logic [plds_pkg::OFFSET_W-1:0]     offset_ff;

   logic signed [plds_pkg::T_W-1:0]   t_ff, t_in;
   logic [UT_W-1:0]                   ut_ff, ut_in;
   logic                              half_ff, half_in;
   logic [2:0]                        band_ff, band_in;
   logic [K_W-1:0]                    k_ff, k_in;
   logic [DIV_W-1:0]                  rem_ff, rem_in;
   logic [N_W-1:0]                    q_ff, q_in;
   logic [IDX_W-1:0]                  div_idx_ff, div_idx_in;
   logic [PROD_W-1:0]                 prod_ff, prod_in;
   logic [K_W-1:0]                    best_k_ff, best_k_in;
   logic [N_W-1:0]                    best_n_ff, best_n_in;
   logic [PROD_W-1:0]                 best_prod_ff, best_prod_in;
   logic [D_W-1:0]                    best_d_ff, best_d_in;
   logic                              found_ff, found_in;
   logic signed [ACT_W-1:0]           act_num_ff, act_num_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_ok_ff, rsp_ok_in;
   logic [2:0]                        rsp_code_ff, rsp_code_in;
   logic [N_W-1:0]                    rsp_n_ff, rsp_n_in;
   logic                              rsp_half_ff, rsp_half_in;
   logic [2:0]                        rsp_band_ff, rsp_band_in;
   logic [UT_W-1:0]                   rsp_hz_ff, rsp_hz_in;

   // ---------------------------------------------------------------------
   // Shared conditions
   // ---------------------------------------------------------------------
   logic                 req_take;
   logic                 slot_free;
   logic                 range_bad;
   logic                 chk_done;
   logic                 chk_skip;
   logic                 mul_skip;
   logic [DIV_W-1:0]     div_sub;
   logic                 div_hit;
   logic [DIFF_W-1:0]    diff;
   logic [D_W-1:0]       d_cur;
   logic                 ev_near;
   logic                 ev_better;
   logic [SH_W-1:0]      refclk_sh;
   logic [ACT_W-1:0]     act_shift;

   assign req_take  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign range_bad = (t_ff < plds_pkg::T_MIN) || (t_ff > plds_pkg::T_MAX);

   // Candidate bound: stop past the largest r or once r*150 kHz exceeds refclk
   assign refclk_sh = SH_W'(refclk_ff);
   assign chk_done  = (k_ff > K_W'(K_MAX)) ||
                      ((SH_W'(plds_pkg::CLK_PER_R_MIN) << k_ff) > refclk_sh);
   assign chk_skip  = (SH_W'(plds_pkg::CLK_PER_R_SKIP) << k_ff) < refclk_sh;
   assign mul_skip  = q_ff < plds_pkg::N_MIN;

   // Divider step: try 2*refclk shifted to the current quotient bit
   assign div_sub = DIV_W'({refclk_ff, 1'b0}) << div_idx_ff;
   assign div_hit = rem_ff >= div_sub;

   // Error of the current candidate, scaled by r
   always_comb begin
      logic [DIFF_W-1:0] tr;
      logic [DIFF_W-1:0] pr;
      tr   = DIFF_W'(ut_ff) << k_ff;
      pr   = DIFF_W'(prod_ff);
      diff = (pr > tr) ? (pr - tr) : (tr - pr);
   end
   assign d_cur     = D_W'(diff);
   assign ev_near   = CMP_W'(d_cur) < (CMP_W'(plds_pkg::ERR_STOP) << k_ff);
   assign ev_better = ((CMP_W'(d_cur) * CMP_W'(10)) << best_k_ff) <
                      ((CMP_W'(best_d_ff) * CMP_W'(9)) << k_ff);

   assign act_shift = $unsigned(act_num_ff) >> best_k_ff;

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         plds_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = plds_pkg::ST_PREP;
            end
         end
         plds_pkg::ST_PREP: begin
            state_in = range_bad ? plds_pkg::ST_FIN : plds_pkg::ST_CHECK;
         end
         plds_pkg::ST_CHECK: begin
            priority if (chk_done) begin
               state_in = found_ff ? plds_pkg::ST_ACT : plds_pkg::ST_FIN;
            end else if (chk_skip) begin
               state_in = plds_pkg::ST_CHECK;
            end else begin
               state_in = plds_pkg::ST_DIV;
            end
         end
         plds_pkg::ST_DIV: begin
            if (div_idx_ff == '0) begin
               state_in = plds_pkg::ST_MUL;
            end
         end
         plds_pkg::ST_MUL: begin
            state_in = mul_skip ? plds_pkg::ST_CHECK : plds_pkg::ST_EVAL;
         end
         plds_pkg::ST_EVAL: begin
            state_in = ev_near ? plds_pkg::ST_ACT : plds_pkg::ST_CHECK;
         end
         plds_pkg::ST_ACT: begin
            state_in = plds_pkg::ST_FIN;
         end
         plds_pkg::ST_FIN: begin
            if (slot_free) begin
               state_in = plds_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = plds_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Datapath and outputs
   // ---------------------------------------------------------------------
   always_comb begin
      logic [plds_pkg::T_W-1:0] vco;
      logic [2:0]               band_cnt;

      t_in         = t_ff;
      ut_in        = ut_ff;
      half_in      = half_ff;
      band_in      = band_ff;
      k_in         = k_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      div_idx_in   = div_idx_ff;
      prod_in      = prod_ff;
      best_k_in    = best_k_ff;
      best_n_in    = best_n_ff;
      best_prod_in = best_prod_ff;
      best_d_in    = best_d_ff;
      found_in     = found_ff;
      act_num_in   = act_num_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ok_in    = rsp_ok_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_n_in     = rsp_n_ff;
      rsp_half_in  = rsp_half_ff;
      rsp_band_in  = rsp_band_ff;
      rsp_hz_in    = rsp_hz_ff;

      vco      = '0;
      band_cnt = '0;

      unique case (state_ff)
         plds_pkg::ST_IDLE: begin
            // target = request - offset, sign-extended
            if (req_take) begin
               t_in = $signed({2'b00, req_requested_hz}) -
                      $signed(plds_pkg::T_W'($signed(offset_ff)));
            end
         end
         plds_pkg::ST_PREP: begin
            ut_in   = t_ff[UT_W-1:0];
            half_in = t_ff[UT_W-1:0] >= plds_pkg::HALF_MIN;
            vco     = half_in ? {1'b0, t_ff[UT_W-1:0], 1'b0} : {t_ff[UT_W-1:0], 2'b00};
            for (int i = 0; i < plds_pkg::BAND_N; i++) begin
               if (vco >= plds_pkg::BAND_EDGE[i]) begin
                  band_cnt = band_cnt + 3'd1;
               end
            end
            band_in   = band_cnt;
            k_in      = K_W'(1);
            best_k_in = '0;
            best_d_in = plds_pkg::ERR_INIT;
            found_in  = 1'b0;
         end
         plds_pkg::ST_CHECK: begin
            priority if (chk_done) begin
               k_in = k_ff;
            end else if (chk_skip) begin
               k_in = k_ff + K_W'(1);
            end else begin
               // numerator 2*t*r + refclk, divided by 2*refclk with rounding
               rem_in     = DIV_W'((NUM_W'(ut_ff) << (k_ff + K_W'(1))) +
                                   NUM_W'(refclk_ff));
               q_in       = '0;
               div_idx_in = IDX_W'(N_W - 1);
            end
         end
         plds_pkg::ST_DIV: begin
            if (div_hit) begin
               rem_in = rem_ff - div_sub;
            end
            q_in = {q_ff[N_W-2:0], div_hit};
            if (div_idx_ff != '0) begin
               div_idx_in = div_idx_ff - IDX_W'(1);
            end
         end
         plds_pkg::ST_MUL: begin
            if (mul_skip) begin
               k_in = k_ff + K_W'(1);
            end else begin
               prod_in = PROD_W'(q_ff) * PROD_W'(refclk_ff);
            end
         end
         plds_pkg::ST_EVAL: begin
            if (ev_near || ev_better) begin
               best_k_in    = k_ff;
               best_n_in    = q_ff;
               best_prod_in = prod_ff;
               found_in     = 1'b1;
            end
            if (!ev_near) begin
               if (ev_better) begin
                  best_d_in = d_cur;
               end
               k_in = k_ff + K_W'(1);
            end
         end
         plds_pkg::ST_ACT: begin
            // 2*t*r - (n+1)*refclk + r/2, divided by r at the end
            act_num_in = $signed(ACT_W'(ut_ff) << (best_k_ff + K_W'(1))) +
                         $signed(ACT_W'(1) << (best_k_ff - K_W'(1))) -
                         $signed(ACT_W'(best_prod_ff)) -
                         $signed(ACT_W'(refclk_ff));
         end
         plds_pkg::ST_FIN: begin
            // load the output register once it is free
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = found_ff;
               if (found_ff) begin
                  rsp_code_in = 3'(best_k_ff - K_W'(1));
                  rsp_n_in    = best_n_ff + N_W'(1);
                  rsp_half_in = half_ff;
                  rsp_band_in = band_ff;
                  priority if (act_num_ff[ACT_W-1]) begin
                     rsp_hz_in = '0;
                  end else if (act_shift > ACT_W'(plds_pkg::SAT_MAX)) begin
                     rsp_hz_in = plds_pkg::SAT_MAX;
                  end else begin
                     rsp_hz_in = act_shift[UT_W-1:0];
                  end
               end else begin
                  rsp_code_in = '0;
                  rsp_n_in    = '0;
                  rsp_half_in = 1'b0;
                  rsp_band_in = '0;
                  rsp_hz_in   = '0;
               end
            end
         end
         default: begin
            found_in = found_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= plds_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         best_k_ff    <= '0;
         div_idx_ff   <= '0;
         refclk_ff    <= plds_pkg::REFCLK_RST;
         offset_ff    <= plds_pkg::OFFSET_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         best_k_ff    <= best_k_in;
         div_idx_ff   <= div_idx_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               plds_pkg::CSR_IDX_REFCLK: refclk_ff <= csr_wdata;
               plds_pkg::CSR_IDX_OFFSET: offset_ff <= csr_wdata[plds_pkg::OFFSET_W-1:0];
               default:                  refclk_ff <= refclk_ff;
            endcase
         end
      end
   end

   // Payload: no reset
   always_ff @(posedge clock) begin
      t_ff         <= t_in;
      ut_ff        <= ut_in;
      half_ff      <= half_in;
      band_ff      <= band_in;
      k_ff         <= k_in;
      rem_ff       <= rem_in;
      q_ff         <= q_in;
      prod_ff      <= prod_in;
      best_n_ff    <= best_n_in;
      best_prod_ff <= best_prod_in;
      best_d_ff    <= best_d_in;
      act_num_ff   <= act_num_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_n_ff     <= rsp_n_in;
      rsp_half_ff  <= rsp_half_in;
      rsp_band_ff  <= rsp_band_in;
      rsp_hz_ff    <= rsp_hz_in;
   end

   assign req_stall        = (state_ff != plds_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_ref_div_code = rsp_code_ff;
   assign rsp_feedback_n   = rsp_n_ff;
   assign rsp_half_mode    = rsp_half_ff;
   assign rsp_vco_band     = rsp_band_ff;
   assign rsp_actual_hz    = rsp_hz_ff;

`ifndef ASSERT_OFF
   // A plan that passes always has a feedback count above 256
   a_ok_n_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ok |-> rsp_feedback_n > plds_pkg::N_MIN)
      else $error("plan with feedback count at or below floor");

   // A failed plan carries all-zero fields
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_feedback_n == '0 && rsp_actual_hz == '0 &&
                               rsp_vco_band == '0 && !rsp_half_mode)
      else $error("failed plan with nonzero fields");

   // The divider runs its full count of steps
   a_div_steps: assert property (@(posedge clock) disable iff (reset)
      state_ff == plds_pkg::ST_DIV && div_idx_ff != '0 |=> state_ff == plds_pkg::ST_DIV)
      else $error("divider left early");

   // A kept candidate always has a legal divider exponent
   a_best_k: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> best_k_ff >= K_W'(1) && best_k_ff <= K_W'(K_MAX))
      else $error("kept candidate exponent out of range");

   // A new response only comes out of the finish step
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == plds_pkg::ST_FIN)
      else $error("response raised outside finish step");
`endif

endmodule
`default_nettype wire
